>>> rtl/core/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, constants and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned NumBlocks = 2048;
  localparam int unsigned HdrAw     = $clog2(NumBlocks);
  localparam int unsigned StepW     = $clog2(NumBlocks);
  localparam int unsigned IdxW      = 12;
  localparam int unsigned CntW      = 13;
  localparam int unsigned PayW      = 11;
  localparam int unsigned HdrW      = IdxW + CntW;

  // one above the last header index of the pool
  localparam logic [IdxW:0] PoolLimit = (IdxW+1)'(NumBlocks);

  typedef enum logic {
    OPC_ALLOC = 1'b0,
    OPC_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_ALLOC       = 2'd0,
    ST_NOFIT       = 2'd1,
    ST_FREED       = 2'd2,
    ST_FREED_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e           opcode;
    logic [PayW-1:0]   block_count;
    logic [PayW-1:0]   handle_index;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [PayW-1:0]   payload_index;
  } rsp_t;

  // header word: link in the upper bits, run length or count in the lower
  typedef struct packed {
    logic [IdxW-1:0]   next;
    logic [CntW-1:0]   count;
  } hdr_t;

  localparam hdr_t HdrInit = '{next: '0, count: CntW'(NumBlocks)};

  typedef enum logic [2:0] {
    ADDR_IND,
    ADDR_NEXT,
    ADDR_TGT,
    ADDR_PREV,
    ADDR_I
  } addr_sel_e;

  typedef enum logic [2:0] {
    WD_ALLOC,
    WD_TGT,
    WD_PREV,
    WD_I_EMPTY,
    WD_I_HEAD,
    WD_I_MID,
    WD_C_LINK
  } wdata_sel_e;

  typedef enum logic {
    HEAD_TGT,
    HEAD_I
  } head_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_A_CHK,
    S_A_WIND,
    S_A_WTGT,
    S_A_LINK,
    S_A_PREV,
    S_F_CNT,
    S_F_WEMPTY,
    S_F_WALK,
    S_F_REREAD,
    S_F_PLACE,
    S_F_LINK,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic       load;
    logic       mem_we;
    addr_sel_e  addr_sel;
    wdata_sel_e wdata_sel;
    logic       rd_latch;
    logic       run_latch;
    logic       step;
    logic       head_ld;
    head_sel_e  head_sel;
    logic       empty_set;
    logic       empty_clr;
    logic       res_ld;
    status_e    res_status;
    logic       out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic empty;
    logic bad_handle;
    logic fits;
    logic nx_zero;
    logic nx_ge_i;
    logic steps_last;
    logic split;
    logic first;
    logic tgt_zero;
    logic c_gt_i;
  } dp_sts_t;

endpackage

>>> rtl/core/ffba_hdr_ram.sv
// ----------------------------------------------------------------------------
// ffba_hdr_ram
// Single-port RAM with registered read data, read-before-write.
// ----------------------------------------------------------------------------
module ffba_hdr_ram #(
  parameter int unsigned DataWidth = 25,
  parameter int unsigned Depth     = 2048,
  parameter int unsigned AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] addr_i,
  input  logic [DataWidth-1:0] wdata_i,
  output logic [DataWidth-1:0] rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> rtl/core/ffba_datapath.sv
// ----------------------------------------------------------------------------
// ffba_datapath
// Header store, free-list registers, list cursor and result registers.
// ----------------------------------------------------------------------------
module ffba_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffba_pkg::req_t    in_data_i,
  input  ffba_pkg::dp_cmd_t cmd_i,
  output ffba_pkg::dp_sts_t sts_o,
  output ffba_pkg::rsp_t    out_data_o
);
  import ffba_pkg::*;

  logic [IdxW-1:0]  head_q;
  logic             empty_q;
  logic             hdr0_init_q;
  req_t             req_q;
  logic [IdxW-1:0]  ind_q;
  logic [IdxW-1:0]  prev_q;
  logic [IdxW-1:0]  i_q;
  logic             first_q;
  logic [StepW-1:0] steps_q;
  logic [CntW-1:0]  cnt_q;
  logic [IdxW-1:0]  nxt_q;
  logic [CntW-1:0]  run_q;
  status_e          res_status_q;
  logic [PayW-1:0]  res_payload_q;
  rsp_t             out_q;
  logic             rd_oob_q;
  logic             rd_ovr_q;

  logic [HdrW-1:0]  ram_rdata;
  hdr_t             rd_hdr;
  logic [IdxW-1:0]  addr;
  logic             in_pool;
  logic             ram_we;
  logic [HdrAw-1:0] ram_addr;
  hdr_t             wdata;
  logic             split;
  logic [IdxW-1:0]  target;
  logic [CntW-1:0]  n_cnt;
  logic [IdxW-1:0]  ind_inc;

  assign n_cnt   = CntW'(req_q.block_count);
  assign split   = cnt_q != (n_cnt + CntW'(1));
  assign target  = split ? (ind_q + IdxW'(req_q.block_count) + IdxW'(1)) : nxt_q;
  assign ind_inc = ind_q + IdxW'(1);

  // out-of-pool headers read as zero, entry 0 reads as the whole pool until written
  always_comb begin
    if (rd_oob_q) begin
      rd_hdr = '0;
    end else if (rd_ovr_q) begin
      rd_hdr = HdrInit;
    end else begin
      rd_hdr = hdr_t'(ram_rdata);
    end
  end

  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_IND:  addr = ind_q;
      ADDR_NEXT: addr = rd_hdr.next;
      ADDR_TGT:  addr = target;
      ADDR_PREV: addr = prev_q;
      ADDR_I:    addr = i_q;
      default:   addr = ind_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wdata_sel)
      WD_ALLOC:   wdata = '{next: nxt_q, count: n_cnt};
      WD_TGT:     wdata = '{next: nxt_q, count: cnt_q - n_cnt - CntW'(1)};
      WD_PREV:    wdata = '{next: target, count: rd_hdr.count};
      WD_I_EMPTY: wdata = '{next: '0, count: run_q};
      WD_I_HEAD:  wdata = '{next: ind_q, count: run_q};
      WD_I_MID:   wdata = '{next: nxt_q, count: run_q};
      WD_C_LINK:  wdata = '{next: i_q, count: (ind_q == i_q) ? run_q : cnt_q};
      default:    wdata = '{next: nxt_q, count: run_q};
    endcase
  end

  assign in_pool  = {1'b0, addr} < PoolLimit;
  assign ram_we   = cmd_i.mem_we && in_pool;
  assign ram_addr = addr[HdrAw-1:0];

  ffba_hdr_ram #(
    .DataWidth (HdrW),
    .Depth     (NumBlocks)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      empty_q     <= 1'b0;
      hdr0_init_q <= 1'b1;
    end else begin
      if (cmd_i.head_ld) begin
        head_q <= (cmd_i.head_sel == HEAD_TGT) ? target : i_q;
      end
      if (cmd_i.empty_set) begin
        empty_q <= 1'b1;
      end else if (cmd_i.empty_clr) begin
        empty_q <= 1'b0;
      end
      if (ram_we && (ram_addr == '0)) begin
        hdr0_init_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_oob_q <= !in_pool;
    rd_ovr_q <= (addr == '0) && hdr0_init_q;
    if (cmd_i.load) begin
      req_q   <= in_data_i;
      ind_q   <= head_q;
      prev_q  <= '0;
      first_q <= 1'b1;
      steps_q <= '0;
      i_q     <= {1'b0, in_data_i.handle_index} - IdxW'(1);
    end else if (cmd_i.step) begin
      prev_q  <= ind_q;
      ind_q   <= rd_hdr.next;
      first_q <= 1'b0;
      steps_q <= steps_q + StepW'(1);
    end
    if (cmd_i.rd_latch) begin
      cnt_q <= rd_hdr.count;
      nxt_q <= rd_hdr.next;
    end
    if (cmd_i.run_latch) begin
      run_q <= rd_hdr.count + CntW'(1);
    end
    if (cmd_i.res_ld) begin
      res_status_q  <= cmd_i.res_status;
      res_payload_q <= (cmd_i.res_status == ST_ALLOC) ? ind_inc[PayW-1:0] : '0;
    end
    if (cmd_i.out_ld) begin
      out_q <= '{status: res_status_q, payload_index: res_payload_q};
    end
  end

  assign sts_o.is_free    = req_q.opcode == OPC_FREE;
  assign sts_o.empty      = empty_q;
  assign sts_o.bad_handle = (req_q.handle_index == '0) ||
                            ({2'b00, req_q.handle_index} >= PoolLimit);
  assign sts_o.fits       = rd_hdr.count > n_cnt;
  assign sts_o.nx_zero    = rd_hdr.next == '0;
  assign sts_o.nx_ge_i    = rd_hdr.next >= i_q;
  assign sts_o.steps_last = steps_q == StepW'(NumBlocks - 1);
  assign sts_o.split      = split;
  assign sts_o.first      = first_q;
  assign sts_o.tgt_zero   = target == '0;
  assign sts_o.c_gt_i     = ind_q > i_q;

  assign out_data_o = out_q;

  a_hdr0_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && (ram_addr == '0) |=> !hdr0_init_q)
    else $error("entry 0 still reads as reset value after a write");

  a_load_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (ind_q == $past(head_q)) && first_q && (steps_q == '0))
    else $error("list cursor not started at the head");

  a_empty_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.empty_set |=> empty_q)
    else $error("empty flag not set after last run taken");

endmodule

>>> rtl/core/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Request sequencer: list walks, header updates and result handoff.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ffba_pkg::dp_sts_t sts_i,
  output ffba_pkg::dp_cmd_t cmd_o
);
  import ffba_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end

      S_DECODE: begin
        if (!sts_i.is_free) begin
          if (sts_i.empty) begin
            cmd_o.res_ld     = 1'b1;
            cmd_o.res_status = ST_NOFIT;
            state_d          = S_DONE;
          end else begin
            cmd_o.addr_sel = ADDR_IND;
            state_d        = S_A_CHK;
          end
        end else if (sts_i.bad_handle) begin
          cmd_o.res_ld     = 1'b1;
          cmd_o.res_status = sts_i.empty ? ST_FREED_EMPTY : ST_FREED;
          state_d          = S_DONE;
        end else begin
          cmd_o.addr_sel = ADDR_I;
          state_d        = S_F_CNT;
        end
      end

      // one header per cycle: the next read is issued from the link just read
      S_A_CHK: begin
        if (sts_i.fits) begin
          cmd_o.rd_latch = 1'b1;
          state_d        = S_A_WIND;
        end else if (sts_i.nx_zero || sts_i.steps_last) begin
          cmd_o.res_ld     = 1'b1;
          cmd_o.res_status = ST_NOFIT;
          state_d          = S_DONE;
        end else begin
          cmd_o.step     = 1'b1;
          cmd_o.addr_sel = ADDR_NEXT;
        end
      end

      S_A_WIND: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.addr_sel  = ADDR_IND;
        cmd_o.wdata_sel = WD_ALLOC;
        state_d         = sts_i.split ? S_A_WTGT : S_A_LINK;
      end

      S_A_WTGT: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.addr_sel  = ADDR_TGT;
        cmd_o.wdata_sel = WD_TGT;
        state_d         = S_A_LINK;
      end

      S_A_LINK: begin
        if (sts_i.first) begin
          if (sts_i.tgt_zero && !sts_i.split) begin
            cmd_o.empty_set = 1'b1;
          end else begin
            cmd_o.head_ld  = 1'b1;
            cmd_o.head_sel = HEAD_TGT;
          end
          cmd_o.res_ld     = 1'b1;
          cmd_o.res_status = ST_ALLOC;
          state_d          = S_DONE;
        end else begin
          cmd_o.addr_sel = ADDR_PREV;
          state_d        = S_A_PREV;
        end
      end

      S_A_PREV: begin
        cmd_o.mem_we     = 1'b1;
        cmd_o.addr_sel   = ADDR_PREV;
        cmd_o.wdata_sel  = WD_PREV;
        cmd_o.res_ld     = 1'b1;
        cmd_o.res_status = ST_ALLOC;
        state_d          = S_DONE;
      end

      S_F_CNT: begin
        cmd_o.run_latch = 1'b1;
        if (sts_i.empty) begin
          state_d = S_F_WEMPTY;
        end else begin
          cmd_o.addr_sel = ADDR_IND;
          state_d        = S_F_WALK;
        end
      end

      S_F_WEMPTY: begin
        cmd_o.mem_we     = 1'b1;
        cmd_o.addr_sel   = ADDR_I;
        cmd_o.wdata_sel  = WD_I_EMPTY;
        cmd_o.head_ld    = 1'b1;
        cmd_o.head_sel   = HEAD_I;
        cmd_o.empty_clr  = 1'b1;
        cmd_o.res_ld     = 1'b1;
        cmd_o.res_status = ST_FREED_EMPTY;
        state_d          = S_DONE;
      end

      S_F_WALK: begin
        if (sts_i.nx_zero || sts_i.nx_ge_i) begin
          cmd_o.rd_latch = 1'b1;
          state_d        = S_F_PLACE;
        end else begin
          cmd_o.step     = 1'b1;
          cmd_o.addr_sel = ADDR_NEXT;
          // walk bound hit: cursor moved without its header in hand
          if (sts_i.steps_last) begin
            state_d = S_F_REREAD;
          end
        end
      end

      S_F_REREAD: begin
        cmd_o.rd_latch = 1'b1;
        state_d        = S_F_PLACE;
      end

      S_F_PLACE: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.addr_sel = ADDR_I;
        if (sts_i.c_gt_i) begin
          cmd_o.wdata_sel  = WD_I_HEAD;
          cmd_o.head_ld    = 1'b1;
          cmd_o.head_sel   = HEAD_I;
          cmd_o.res_ld     = 1'b1;
          cmd_o.res_status = ST_FREED;
          state_d          = S_DONE;
        end else begin
          cmd_o.wdata_sel = WD_I_MID;
          state_d         = S_F_LINK;
        end
      end

      S_F_LINK: begin
        cmd_o.mem_we     = 1'b1;
        cmd_o.addr_sel   = ADDR_IND;
        cmd_o.wdata_sel  = WD_C_LINK;
        cmd_o.res_ld     = 1'b1;
        cmd_o.res_status = ST_FREED;
        state_d          = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DECODE)
    else $error("accepted request not decoded");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result beat raised outside handoff");

  a_handoff_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !out_valid_q |=> state_q == S_IDLE && out_valid_q)
    else $error("result not handed off to empty output slot");

endmodule

>>> rtl/core/first_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit allocator over a pool of fixed-size blocks with an address-ordered
// free list kept in a header RAM.
// ----------------------------------------------------------------------------
// One request at a time. An allocate reads free runs along the list until one
// fits or the list ends, then writes the updated headers; a free walks the list
// to its place, then writes its own header and, if needed, the link of the run
// before it. Every link costs one read of the single-port header RAM. A finished
// result sits in an output register, and the next request is accepted while it
// waits. No clearing pass after reset: only header 0 has a reset value, held by
// a flag until it is first written.
module first_fit_block_allocator_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ffba_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ffba_pkg::rsp_t out_data_o
);
  import ffba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffba_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
